### src/tssd_pkg.sv
// tssd_pkg: request types, sensor constants and helper functions for the
// scratchpad temperature decoder; no dependencies

package tssd_pkg;

    localparam logic [7:0] FAMILY_NINE_BIT = 8'h10;
    localparam logic [7:0] FAMILY_PROG_RES = 8'h28;
    localparam logic [3:0] LAST_INDEX      = 4'd8;
    localparam logic [3:0] IDX_TEMP_LOW    = 4'd0;
    localparam logic [3:0] IDX_TEMP_HIGH   = 4'd1;
    localparam logic [3:0] IDX_CONFIG      = 4'd4;
    localparam logic [3:0] IDX_COUNT_REM   = 4'd6;
    localparam logic [7:0] CRC_POLY        = 8'h8C;
    localparam logic [15:0] NINE_BIT_BIAS  = 16'd12;

    localparam logic [1:0] RES_12BIT = 2'b11;
    localparam logic [1:0] RES_11BIT = 2'b10;
    localparam logic [1:0] RES_10BIT = 2'b01;

    typedef struct packed {
        logic [7:0] scratch_byte;
        logic [7:0] family_code;
    } t_in_req;

    typedef struct packed {
        logic        status;
        logic        negative;
        logic [7:0]  whole_degrees;
        logic [3:0]  fraction_sixteenths;
        logic [15:0] magnitude;
        logic [11:0] decicelsius;
    } t_out_req;

    // frame state handed from the byte collector to the decoder
    typedef struct packed {
        logic       last;
        logic       crc_ok;
        logic [7:0] temp_low;
        logic [7:0] temp_high;
        logic [7:0] resolution;
        logic [7:0] count_remain;
    } t_frame;

    // reflected crc-8, one byte, bitwise over eight steps
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // floor(frac * 625 / 1000) for the sixteen fraction codes
    function automatic logic [3:0] frac_tenths(input logic [3:0] frac);
        logic [3:0] t;
        case (frac)
            4'd0:    t = 4'd0;
            4'd1:    t = 4'd0;
            4'd2:    t = 4'd1;
            4'd3:    t = 4'd1;
            4'd4:    t = 4'd2;
            4'd5:    t = 4'd3;
            4'd6:    t = 4'd3;
            4'd7:    t = 4'd4;
            4'd8:    t = 4'd5;
            4'd9:    t = 4'd5;
            4'd10:   t = 4'd6;
            4'd11:   t = 4'd6;
            4'd12:   t = 4'd7;
            4'd13:   t = 4'd8;
            4'd14:   t = 4'd8;
            4'd15:   t = 4'd9;
            default: t = 4'd0;
        endcase
        return t;
    endfunction

    // fractions that round up by one tenth on positive readings
    function automatic logic frac_rounds_up(input logic [3:0] frac);
        logic r;
        case (frac)
            4'd1, 4'd3, 4'd4, 4'd6, 4'd9, 4'd11, 4'd12, 4'd14: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### src/temp_sensor_scratchpad_decode.sv
// temp_sensor_scratchpad_decode: top level with input register, frame collector, decoder
// and result register; depends on tssd_pkg, tssd_frame, tssd_decode
// o_out_valid is registered: set once the held ninth byte of a frame is worked on;
// bytes that end no frame produce no result
// throughput: one byte per cycle; a ninth byte waits while an unaccepted result is held
// reset: synchronous active-low, empties both registers and restarts byte count and crc

module temp_sensor_scratchpad_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tssd_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tssd_pkg::t_out_req o_out_req
);

    // input register
    logic               r_in_valid;
    tssd_pkg::t_in_req  r_in;

    // result register
    logic               r_out_valid;
    tssd_pkg::t_out_req r_out;

    logic               w_out_free;
    logic               w_proc;
    logic               w_in_free;
    tssd_pkg::t_frame   w_frame;
    tssd_pkg::t_out_req w_result;

    // result register can take a new request when empty or being drained
    assign w_out_free = !r_out_valid || !i_out_stall;
    // a held byte is worked on unless it ends a frame and the result slot is busy
    assign w_proc     = r_in_valid && (!w_frame.last || w_out_free);
    assign w_in_free  = !r_in_valid || w_proc;
    assign o_in_stall = !w_in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_free && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    // crc and byte capture
    tssd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_proc  (w_proc),
        .i_byte  (r_in.scratch_byte),
        .o_frame (w_frame)
    );

    // decode of the finished frame, family taken with the ninth byte
    tssd_decode u_decode (
        .i_frame  (w_frame),
        .i_family (r_in.family_code),
        .o_req    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_proc && w_frame.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_frame.last) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");
    a_result_follows_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_frame.last |=> r_out_valid)
        else $error("frame end gave no result");
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_proc && w_frame.last))
        else $error("result appeared without a frame end");
    a_crc_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status |-> r_out.magnitude == 16'd0
            && r_out.decicelsius == 12'd0 && !r_out.negative)
        else $error("crc error result carries data");
`endif

endmodule

### src/tssd_frame.sv
// tssd_frame: byte counter, running crc-8 and capture of the temperature,
// config and count-remain bytes; depends on tssd_pkg

module tssd_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_proc,
    input  logic [7:0]        i_byte,
    output tssd_pkg::t_frame  o_frame
);

    logic [7:0] r_crc;
    logic [3:0] r_idx;
    logic [7:0] r_temp_low;
    logic [7:0] r_temp_high;
    logic [7:0] r_resolution;
    logic [7:0] r_count_remain;
    logic [7:0] n_crc;
    logic       w_last;

    assign n_crc  = tssd_pkg::crc8_update(r_crc, i_byte);
    assign w_last = (r_idx == tssd_pkg::LAST_INDEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 8'd0;
            r_idx <= 4'd0;
        end else if (i_proc) begin
            if (w_last) begin
                r_crc <= 8'd0;
                r_idx <= 4'd0;
            end else begin
                r_crc <= n_crc;
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_proc) begin
            if (r_idx == tssd_pkg::IDX_TEMP_LOW)  r_temp_low     <= i_byte;
            if (r_idx == tssd_pkg::IDX_TEMP_HIGH) r_temp_high    <= i_byte;
            if (r_idx == tssd_pkg::IDX_CONFIG)    r_resolution   <= i_byte;
            if (r_idx == tssd_pkg::IDX_COUNT_REM) r_count_remain <= i_byte;
        end
    end

    always_comb begin
        o_frame.last         = w_last;
        o_frame.crc_ok       = (n_crc == 8'd0);
        o_frame.temp_low     = r_temp_low;
        o_frame.temp_high    = r_temp_high;
        o_frame.resolution   = r_resolution;
        o_frame.count_remain = r_count_remain;
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= tssd_pkg::LAST_INDEX)
        else $error("byte index beyond frame");
    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_proc && w_last |=> r_crc == 8'd0 && r_idx == 4'd0)
        else $error("frame state not restarted after last byte");
`endif

endmodule

### src/tssd_decode.sv
// tssd_decode: turns a completed frame into one result request
// (crc check, nine-bit fix, sign, resolution mask, decicelsius); depends on tssd_pkg

module tssd_decode (
    input  tssd_pkg::t_frame   i_frame,
    input  logic [7:0]         i_family,
    output tssd_pkg::t_out_req o_req
);

    logic [15:0] w_raw;
    logic [15:0] w_fixed;
    logic        w_neg;
    logic [15:0] w_abs;
    logic [15:0] w_mag;
    logic [7:0]  w_whole;
    logic [3:0]  w_frac;
    logic [11:0] w_deci;

    always_comb begin
        w_raw = {i_frame.temp_high, i_frame.temp_low};
        if (i_family == tssd_pkg::FAMILY_NINE_BIT) begin
            // drop the half-degree bit, scale to sixteenths, apply count remain
            w_fixed = {w_raw[12:1], 4'b0000} + tssd_pkg::NINE_BIT_BIAS
                      - {8'd0, i_frame.count_remain};
        end else begin
            w_fixed = w_raw;
        end
        w_neg = w_fixed[15];
        w_abs = w_neg ? (~w_fixed + 16'd1) : w_fixed;
        w_mag = w_abs;
        if (i_family == tssd_pkg::FAMILY_PROG_RES) begin
            case (i_frame.resolution[6:5])
                tssd_pkg::RES_12BIT: w_mag = w_abs;
                tssd_pkg::RES_11BIT: w_mag = {w_abs[15:1], 1'b0};
                tssd_pkg::RES_10BIT: w_mag = {w_abs[15:2], 2'b00};
                default:             w_mag = {w_abs[15:3], 3'b000};
            endcase
        end
        w_whole = w_mag[11:4];
        w_frac  = w_mag[3:0];
        w_deci  = {4'd0, w_whole} * 12'd10 + {8'd0, tssd_pkg::frac_tenths(w_frac)}
                  + {11'd0, (!w_neg && tssd_pkg::frac_rounds_up(w_frac))};

        if (!i_frame.crc_ok) begin
            o_req = '0;
            o_req.status = 1'b1;
        end else begin
            o_req.status              = 1'b0;
            o_req.negative            = w_neg;
            o_req.whole_degrees       = w_whole;
            o_req.fraction_sixteenths = w_frac;
            o_req.magnitude           = w_mag;
            o_req.decicelsius         = w_deci;
        end
    end

endmodule
